### rtl/fadd_pkg.sv
// ----------------------------------------------------------------------------
// fadd_pkg: shared types and constants
// Class codes and the result payload record of the truncating adder.
// ----------------------------------------------------------------------------
package fadd_pkg;
  localparam int WORD_WIDTH = 32;
  localparam int CLASS_WIDTH = 3;

  localparam logic [CLASS_WIDTH-1:0] CLASS_ZERO = 3'd0;
  localparam logic [CLASS_WIDTH-1:0] CLASS_SUBNORMAL = 3'd1;
  localparam logic [CLASS_WIDTH-1:0] CLASS_NORMAL = 3'd2;
  localparam logic [CLASS_WIDTH-1:0] CLASS_INFINITY = 3'd3;
  localparam logic [CLASS_WIDTH-1:0] CLASS_NAN = 3'd4;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] sum_bits;
    logic [CLASS_WIDTH-1:0] result_class;
  } result_t;
endpackage

### rtl/fadd_if.sv
// ----------------------------------------------------------------------------
// fadd_if: valid/ready channel
// Carries one payload of parameter width with a valid/ready transfer.
// ----------------------------------------------------------------------------
interface fadd_if #(parameter int WIDTH = 64) ();
  logic valid;
  logic ready;
  logic [WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/fadd_align.sv
// ----------------------------------------------------------------------------
// fadd_align: unpack and align stage
// Unpack both operands, shift the smaller one right with sticky.
// ----------------------------------------------------------------------------
module fadd_align
  import fadd_pkg::*;
#(
  parameter int EXP_WIDTH = 8,
  parameter int FRAC_WIDTH = 23,
  parameter int GUARD_WIDTH = 3
) (
  input  logic [WORD_WIDTH-1:0] operand_a,
  input  logic [WORD_WIDTH-1:0] operand_b,
  output logic sign_a,
  output logic sign_b,
  output logic [EXP_WIDTH-1:0] expo,
  output logic [FRAC_WIDTH+GUARD_WIDTH:0] mag_a,
  output logic [FRAC_WIDTH+GUARD_WIDTH:0] mag_b
);
  localparam int SW = FRAC_WIDTH + GUARD_WIDTH + 1;

  logic [EXP_WIDTH-1:0] ea, eb, fa, fb, gap;
  logic [SW-1:0] ma, mb, lesser, shifted, lost;
  logic [FRAC_WIDTH-1:0] xa, xb;
  logic a_less, sticky;

  always_comb begin
    xa = operand_a[FRAC_WIDTH-1:0];
    xb = operand_b[FRAC_WIDTH-1:0];
    fa = operand_a[FRAC_WIDTH +: EXP_WIDTH];
    fb = operand_b[FRAC_WIDTH +: EXP_WIDTH];
    ea = (fa == '0) ? ((xa == '0) ? '0 : EXP_WIDTH'(1)) : fa;
    eb = (fb == '0) ? ((xb == '0) ? '0 : EXP_WIDTH'(1)) : fb;
    ma = {(fa != '0), xa, {GUARD_WIDTH{1'b0}}};
    mb = {(fb != '0), xb, {GUARD_WIDTH{1'b0}}};
    a_less = ea < eb;
    gap = a_less ? (eb - ea) : (ea - eb);
    lesser = a_less ? ma : mb;
    if (gap >= EXP_WIDTH'(SW)) begin
      shifted = '0;
      lost = lesser;
    end else begin
      shifted = lesser >> gap;
      lost = lesser & ~({SW{1'b1}} << gap);
    end
    sticky = lost != '0;
    sign_a = operand_a[EXP_WIDTH+FRAC_WIDTH];
    sign_b = operand_b[EXP_WIDTH+FRAC_WIDTH];
    expo = a_less ? eb : ea;
    mag_a = a_less ? (shifted | SW'(sticky)) : ma;
    mag_b = a_less ? mb : (shifted | SW'(sticky));
  end
endmodule

### rtl/fadd_norm.sv
// ----------------------------------------------------------------------------
// fadd_norm: normalize and pack stage
// Count leading zeros, shift to normalize, truncate and classify.
// ----------------------------------------------------------------------------
module fadd_norm
  import fadd_pkg::*;
#(
  parameter int EXP_WIDTH = 8,
  parameter int FRAC_WIDTH = 23,
  parameter int GUARD_WIDTH = 3
) (
  input  logic sign,
  input  logic [EXP_WIDTH-1:0] expo_in,
  input  logic [FRAC_WIDTH+GUARD_WIDTH:0] mag_in,
  output result_t result
);
  localparam int SW = FRAC_WIDTH + GUARD_WIDTH + 1;
  localparam int LW = $clog2(SW + 1);

  logic [LW-1:0] lz;
  logic [EXP_WIDTH-1:0] expo, frac_zero;
  logic [SW-1:0] mag;
  logic [FRAC_WIDTH-1:0] frac;
  logic found;

  always_comb begin
    lz = LW'(SW);
    found = 1'b0;
    for (int i = SW - 1; i >= 0; i--) begin
      if (!found && mag_in[i]) begin
        lz = LW'(SW - 1 - i);
        found = 1'b1;
      end
    end
    frac_zero = '0;
    if (expo_in == '0) begin
      expo = '0;
      mag = mag_in >> 1;
    end else if (found && ({{EXP_WIDTH{1'b0}}, lz} < {{LW{1'b0}}, expo_in})) begin
      expo = expo_in - EXP_WIDTH'(lz);
      mag = mag_in << lz;
    end else begin
      expo = '0;
      mag = (mag_in << (expo_in - EXP_WIDTH'(1)));
    end
    frac = mag[GUARD_WIDTH +: FRAC_WIDTH];
    if (expo == {EXP_WIDTH{1'b1}}) frac = FRAC_WIDTH'(frac_zero);
    result.sum_bits = WORD_WIDTH'({sign, expo, frac});
    if (expo == '0) begin
      result.result_class = (frac == '0) ? CLASS_ZERO : CLASS_SUBNORMAL;
    end else if (expo == {EXP_WIDTH{1'b1}}) begin
      result.result_class = (frac == '0) ? CLASS_INFINITY : CLASS_NAN;
    end else begin
      result.result_class = CLASS_NORMAL;
    end
  end
endmodule

### rtl/float32_adder_truncating.sv
// ----------------------------------------------------------------------------
// float32_adder_truncating: truncating binary32 adder
// The align, add and normalize results are registered in turn in s1, s2 and
// the output register; one item per cycle while the output is not stalled.
// Stages: align, add, normalize; the output register is the third stage.
// A stall holds every full stage whose successor cannot advance; nothing is dropped.
// Synchronous active-high reset clears all stage valid bits.
// ----------------------------------------------------------------------------
module float32_adder_truncating
  import fadd_pkg::*;
#(
  parameter int EXP_WIDTH = 8,
  parameter int FRAC_WIDTH = 23,
  parameter int GUARD_WIDTH = 3
) (
  input logic clk,
  input logic rst,
  fadd_if.sink in_ch,
  fadd_if.source out_ch
);
  localparam int SW = FRAC_WIDTH + GUARD_WIDTH + 1;

  logic v1, v2, v3;
  logic adv1, adv2, adv3;
  logic s1_sa, s1_sb, s2_sign;
  logic [EXP_WIDTH-1:0] s1_expo, s2_expo, a_expo, c_expo;
  logic [SW-1:0] s1_ma, s1_mb, a_ma, a_mb, s2_mag, c_mag;
  logic [SW:0] sum_full;
  logic a_sa, a_sb, c_sign;
  result_t res, out_res;

  fadd_align #(.EXP_WIDTH(EXP_WIDTH), .FRAC_WIDTH(FRAC_WIDTH),
               .GUARD_WIDTH(GUARD_WIDTH)) u_align (
    .operand_a(in_ch.data[WORD_WIDTH-1:0]),
    .operand_b(in_ch.data[2*WORD_WIDTH-1:WORD_WIDTH]),
    .sign_a(a_sa), .sign_b(a_sb), .expo(a_expo), .mag_a(a_ma), .mag_b(a_mb)
  );

  assign adv3 = !v3 || out_ch.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ch.ready = adv1;

  always_comb begin
    c_sign = s1_sa;
    if (s1_sa != s1_sb) begin
      if (s1_ma < s1_mb) begin
        c_sign = s1_sb;
        sum_full = {1'b0, s1_mb - s1_ma};
      end else begin
        sum_full = {1'b0, s1_ma - s1_mb};
      end
    end else begin
      sum_full = {1'b0, s1_ma} + {1'b0, s1_mb};
    end
    c_expo = s1_expo;
    c_mag = sum_full[SW-1:0];
    if (sum_full[SW]) begin
      if (s1_expo != {EXP_WIDTH{1'b1}}) begin
        c_mag = sum_full[SW:1];
        c_expo = s1_expo + EXP_WIDTH'(1);
      end else begin
        c_mag = '0;
      end
    end
  end

  fadd_norm #(.EXP_WIDTH(EXP_WIDTH), .FRAC_WIDTH(FRAC_WIDTH),
              .GUARD_WIDTH(GUARD_WIDTH)) u_norm (
    .sign(s2_sign), .expo_in(s2_expo), .mag_in(s2_mag), .result(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_ch.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1) begin
      s1_sa <= a_sa;
      s1_sb <= a_sb;
      s1_expo <= a_expo;
      s1_ma <= a_ma;
      s1_mb <= a_mb;
    end
    if (adv2) begin
      s2_sign <= c_sign;
      s2_expo <= c_expo;
      s2_mag <= c_mag;
    end
    if (adv3) out_res <= res;
  end

  assign out_ch.valid = v3;
  assign out_ch.data = {out_res.result_class, out_res.sum_bits};

  a_no_nan: assert property (@(posedge clk) disable iff (rst)
    v3 |-> out_res.result_class != CLASS_NAN) else $error("nan class");
  a_inf_frac: assert property (@(posedge clk) disable iff (rst)
    v3 && out_res.result_class == CLASS_INFINITY
      |-> out_res.sum_bits[FRAC_WIDTH-1:0] == '0) else $error("inf fraction");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && v3 && !out_ch.ready |=> v2) else $error("stage 2 lost");
endmodule
